>>> sv/handheld_timer_divider_unit_macros.svh
`ifndef HANDHELD_TIMER_DIVIDER_UNIT_MACROS_SVH
`define HANDHELD_TIMER_DIVIDER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/htd_pkg.sv
package htd_pkg;

    localparam int ACCUM_W = 11;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] REG_DIVIDER = 2'd0;
    localparam logic [1:0] REG_COUNTER = 2'd1;
    localparam logic [1:0] REG_MODULO  = 2'd2;
    localparam logic [1:0] REG_CONTROL = 2'd3;

    localparam int CTRL_ENABLE_BIT = 2;

    localparam logic [15:0] DIVIDER_RESET = 16'hAB00;
    localparam logic [7:0]  CONTROL_RESET = 8'hF8;

    typedef struct packed {
        logic               ge;
        logic [ACCUM_W-1:0] accum;
        logic [7:0]         counter;
        logic               wrap;
    } htd_step_t;

    function automatic logic [ACCUM_W-1:0] period_of(input logic [1:0] sel);
        logic [ACCUM_W-1:0] p;
        unique case (sel)
            2'd0: p = 11'd1024;
            2'd1: p = 11'd16;
            2'd2: p = 11'd64;
            2'd3: p = 11'd256;
            default: p = 11'd1024;
        endcase
        return p;
    endfunction

endpackage

>>> sv/htd_period_unit.sv
module htd_period_unit (
    input  logic [htd_pkg::ACCUM_W-1:0] accum,
    input  logic [htd_pkg::ACCUM_W-1:0] period,
    input  logic [7:0]                  counter,
    input  logic [7:0]                  modulo,
    output htd_pkg::htd_step_t          step
);

    logic [7:0] counter_inc;

    assign counter_inc  = counter + 8'd1;
    assign step.ge      = (accum >= period);
    assign step.accum   = accum - period;
    assign step.wrap    = (counter_inc == 8'd0);
    assign step.counter = step.wrap ? modulo : counter_inc;

endmodule

>>> sv/handheld_timer_divider_unit.sv
// Channel   Dir  Bits              Contents
// s_axis    in   tdata[15:0]       wdata, dots
//                tuser[3:0]        op, reg_sel
// m_axis    out  tdata[15:0]       rdata, timer_irq
//
// Reads, writes and ticks with the timer off go from ST_IDLE through ST_FINISH into
// the output register. Enabled ticks go through ST_DRAIN first, making N counter
// increments, up to 79 at period 16; a single subtractor drains a period per cycle.
// s_axis_tready is high only while no item is in work; a finished result waits in
// the output register while the next item is taken. rst_n resets all but data regs.
`include "handheld_timer_divider_unit_macros.svh"

module handheld_timer_divider_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] wdata, [15:8] dots
    input  logic [3:0]  s_axis_tuser,   // [1:0] op, [3:2] reg_sel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] rdata, [8] timer_irq, [15:9] zero
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]                  divider_reg, divider_next;
    logic [htd_pkg::ACCUM_W-1:0]  accum_reg, accum_next;
    logic [htd_pkg::ACCUM_W-1:0]  period_reg, period_next;
    logic [7:0]                   counter_reg, counter_next;
    logic [7:0]                   modulo_reg, modulo_next;
    logic [7:0]                   control_reg, control_next;
    logic [7:0]                   res_rdata_reg, res_rdata_next;
    logic                         res_irq_reg, res_irq_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_rdata_reg, out_rdata_next;
    logic                         out_irq_reg, out_irq_next;

    logic [1:0] op;
    logic [1:0] reg_sel;
    logic [7:0] wdata;
    logic [7:0] dots;
    logic       s_accept;
    logic       m_accept;

    htd_pkg::htd_step_t step;

    assign op       = s_axis_tuser[1:0];
    assign reg_sel  = s_axis_tuser[3:2];
    assign wdata    = s_axis_tdata[7:0];
    assign dots     = s_axis_tdata[15:8];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_accept      = out_valid_reg && m_axis_tready;
    assign m_axis_tdata  = {7'd0, out_irq_reg, out_rdata_reg};

    htd_period_unit u_period (
        .accum   (accum_reg),
        .period  (period_reg),
        .counter (counter_reg),
        .modulo  (modulo_reg),
        .step    (step)
    );

    always_comb
    begin
        state_next     = state_reg;
        divider_next   = divider_reg;
        accum_next     = accum_reg;
        period_next    = period_reg;
        counter_next   = counter_reg;
        modulo_next    = modulo_reg;
        control_next   = control_reg;
        res_rdata_next = res_rdata_reg;
        res_irq_next   = res_irq_reg;
        out_valid_next = out_valid_reg;
        out_rdata_next = out_rdata_reg;
        out_irq_next   = out_irq_reg;

        if (m_accept)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    res_rdata_next = 8'd0;
                    res_irq_next   = 1'b0;
                    state_next     = ST_FINISH;
                    unique case (op)
                        htd_pkg::OP_TICK:
                        begin
                            divider_next = divider_reg + {8'd0, dots};
                            if (control_reg[htd_pkg::CTRL_ENABLE_BIT])
                            begin
                                accum_next  = accum_reg + {3'd0, dots};
                                period_next = htd_pkg::period_of(control_reg[1:0]);
                                state_next  = ST_DRAIN;
                            end
                        end
                        htd_pkg::OP_READ:
                        begin
                            unique case (reg_sel)
                                htd_pkg::REG_DIVIDER: res_rdata_next = divider_reg[15:8];
                                htd_pkg::REG_COUNTER: res_rdata_next = counter_reg;
                                htd_pkg::REG_MODULO:  res_rdata_next = modulo_reg;
                                htd_pkg::REG_CONTROL: res_rdata_next = control_reg;
                                default:              res_rdata_next = 8'd0;
                            endcase
                        end
                        htd_pkg::OP_WRITE:
                        begin
                            unique case (reg_sel)
                                htd_pkg::REG_DIVIDER:
                                begin
                                    divider_next = 16'd0;
                                    accum_next   = '0;
                                end
                                htd_pkg::REG_COUNTER: counter_next = wdata;
                                htd_pkg::REG_MODULO:  modulo_next  = wdata;
                                htd_pkg::REG_CONTROL: control_next = wdata;
                                default:              control_next = control_reg;
                            endcase
                        end
                        default:
                        begin
                            res_rdata_next = 8'd0;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (step.ge)
                begin
                    accum_next   = step.accum;
                    counter_next = step.counter;
                    if (step.wrap)
                    begin
                        res_irq_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_rdata_next = res_rdata_reg;
                    out_irq_next   = res_irq_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            divider_reg   <= htd_pkg::DIVIDER_RESET;
            accum_reg     <= '0;
            counter_reg   <= 8'd0;
            modulo_reg    <= 8'd0;
            control_reg   <= htd_pkg::CONTROL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            divider_reg   <= divider_next;
            accum_reg     <= accum_next;
            counter_reg   <= counter_next;
            modulo_reg    <= modulo_next;
            control_reg   <= control_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg    <= period_next;
        res_rdata_reg <= res_rdata_next;
        res_irq_reg   <= res_irq_next;
        out_rdata_reg <= out_rdata_next;
        out_irq_reg   <= out_irq_next;
    end

    `HTD_ASSERT_NEXT(a_drain_ends, (state_reg == ST_DRAIN) && !step.ge, state_reg == ST_FINISH, "drain did not end when remainder fell below period")
    `HTD_ASSERT_NEXT(a_access_finish, s_accept && (op != htd_pkg::OP_TICK), state_reg == ST_FINISH, "register access did not go straight to result")
    `HTD_ASSERT_NEXT(a_result_loaded, (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready), out_valid_reg && (state_reg == ST_IDLE), "result not moved to output register")
    `HTD_ASSERT_NEXT(a_off_tick_hold, s_accept && (op == htd_pkg::OP_TICK) && !control_reg[htd_pkg::CTRL_ENABLE_BIT], $stable(accum_reg) && $stable(counter_reg), "disabled tick moved the timer")
    `HTD_ASSERT_NOW(a_irq_only_tick, m_axis_tvalid && m_axis_tdata[8], m_axis_tdata[7:0] == 8'd0, "interrupt flag on a non-tick result")

endmodule
